FILE: src/gnll_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian NLL loss package
// Shared types, datapath command codes, constants and helper functions.
// ----------------------------------------------------------------------------
package gnll_pkg;

	localparam int COUNT_BITS = 24;
	localparam int LN2_Q16    = 45426;
	localparam int NUM_W      = 65;
	localparam int DEN_W      = 33;
	localparam int DIV_STEPS  = NUM_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_EPS         = 2'd0;
	localparam logic [1:0] REG_GRAD_SCALE  = 2'd1;
	localparam logic [1:0] REG_LOSS_OFFSET = 2'd2;
	localparam logic [1:0] REG_GRAD_SELECT = 2'd3;

	// Datapath operations.
	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_LOAD      = 4'd1;
	localparam logic [3:0] OP_MUL       = 4'd2;
	localparam logic [3:0] OP_DIV_START = 4'd3;
	localparam logic [3:0] OP_DIV_STEP  = 4'd4;
	localparam logic [3:0] OP_LOG_START = 4'd5;
	localparam logic [3:0] OP_LOG_NORM  = 4'd6;
	localparam logic [3:0] OP_LOG_ITER  = 4'd7;
	localparam logic [3:0] OP_ACC       = 4'd8;
	localparam logic [3:0] OP_CALC_W    = 4'd9;
	localparam logic [3:0] OP_FINISH    = 4'd10;

	// Operand selects for the multiplier and the divider.
	localparam logic [2:0] SEL_SQ   = 3'd0;
	localparam logic [2:0] SEL_MG   = 3'd1;
	localparam logic [2:0] SEL_R    = 3'd2;
	localparam logic [2:0] SEL_A    = 3'd3;
	localparam logic [2:0] SEL_LOSS = 3'd4;
	localparam logic [2:0] SEL_R2   = 3'd5;
	localparam logic [2:0] SEL_WLO  = 3'd6;
	localparam logic [2:0] SEL_WHI  = 3'd7;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] sel;
	} gnll_cmd_t;

	typedef struct packed {
		logic div_last;
		logic norm_done;
		logic iter_done;
		logic last;
		logic out_free;
	} gnll_status_t;

	typedef struct packed {
		logic [30:0] eps;
		logic [31:0] grad_scale;
		logic [31:0] loss_offset;
		logic [1:0]  grad_select;
	} gnll_cfg_t;

	// ln(1 + 2^-i) in Q16.16.
	function automatic logic [15:0] ln_tab(input logic [4:0] i);
		logic [15:0] r;
		case (i)
			5'd1:    r = 16'd26573;
			5'd2:    r = 16'd14624;
			5'd3:    r = 16'd7719;
			5'd4:    r = 16'd3973;
			5'd5:    r = 16'd2017;
			5'd6:    r = 16'd1016;
			5'd7:    r = 16'd510;
			5'd8:    r = 16'd256;
			5'd9:    r = 16'd128;
			5'd10:   r = 16'd64;
			5'd11:   r = 16'd32;
			5'd12:   r = 16'd16;
			5'd13:   r = 16'd8;
			5'd14:   r = 16'd4;
			5'd15:   r = 16'd2;
			5'd16:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// Applies a sign to a magnitude and saturates to 32 bits.
	function automatic logic [31:0] sat_mag(input logic [64:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = (mag >= 65'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
		end else begin
			r = (mag >= 65'h0_7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
		end
		return r;
	endfunction

endpackage

FILE: src/gaussian_nll_loss_top.sv
// ----------------------------------------------------------------------------
// Gaussian NLL loss top level
// Configuration registers, sequencing controller and arithmetic datapath.
// ----------------------------------------------------------------------------
// Each item carries one element (mean, variance, label in Q16.16 and a last
// flag) and yields one result item with the mean and variance gradients and,
// on the last element of a set, the finished mean loss. The block works on one
// item at a time. Four radix-2 divides through the single shared divider
// make up most of the work on an item (a fifth one runs for the loss on a
// last element), and the log unit adds up to 31 normalizing shifts plus 16
// table steps. A finished result waits in the output register while the
// next item is already being accepted and worked on. Configuration registers
// are written through the plain write port and should only be changed while
// no item is in flight.
// ----------------------------------------------------------------------------
module gaussian_nll_loss_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] mean,
	input  logic [30:0] variance,
	input  logic [31:0] label,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] mean_grad,
	output logic [31:0] var_grad,
	output logic [31:0] loss,
	output logic        loss_valid
);

	gnll_pkg::gnll_cfg_t    cfg_q;
	gnll_pkg::gnll_cmd_t    cmd;
	gnll_pkg::gnll_status_t status;
	logic                   busy;

	// Configuration registers; every index of the port maps to a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eps         <= 31'd66;
			cfg_q.grad_scale  <= 32'd65536;
			cfg_q.loss_offset <= 32'd26155;
			cfg_q.grad_select <= 2'd3;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gnll_pkg::REG_EPS:         cfg_q.eps         <= cfg_data[30:0];
				gnll_pkg::REG_GRAD_SCALE:  cfg_q.grad_scale  <= cfg_data;
				gnll_pkg::REG_LOSS_OFFSET: cfg_q.loss_offset <= cfg_data;
				gnll_pkg::REG_GRAD_SELECT: cfg_q.grad_select <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// The input side is held off whenever the sequencer is busy with an item.
	assign in_stall = busy;

	gnll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.busy     (busy),
		.status   (status),
		.cmd      (cmd)
	);

	gnll_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg        (cfg_q),
		.mean       (mean),
		.variance   (variance),
		.label      (label),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mean_grad  (mean_grad),
		.var_grad   (var_grad),
		.loss       (loss),
		.loss_valid (loss_valid)
	);

endmodule

FILE: src/gnll_ctrl.sv
// ----------------------------------------------------------------------------
// Gaussian NLL loss controller
// Sequences the shared multiplier, divider and log unit for one item.
// ----------------------------------------------------------------------------
module gnll_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   busy,
	input  gnll_pkg::gnll_status_t status,
	output gnll_pkg::gnll_cmd_t    cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_MSQ  = 5'd1;
	localparam logic [4:0] S_SSQ  = 5'd2;
	localparam logic [4:0] S_DSQ  = 5'd3;
	localparam logic [4:0] S_MMG  = 5'd4;
	localparam logic [4:0] S_SMG  = 5'd5;
	localparam logic [4:0] S_DMG  = 5'd6;
	localparam logic [4:0] S_LNS  = 5'd7;
	localparam logic [4:0] S_LNN  = 5'd8;
	localparam logic [4:0] S_LNI  = 5'd9;
	localparam logic [4:0] S_ACC  = 5'd10;
	localparam logic [4:0] S_SR   = 5'd11;
	localparam logic [4:0] S_DR   = 5'd12;
	localparam logic [4:0] S_MR2  = 5'd13;
	localparam logic [4:0] S_SA   = 5'd14;
	localparam logic [4:0] S_DA   = 5'd15;
	localparam logic [4:0] S_MW   = 5'd16;
	localparam logic [4:0] S_MWL  = 5'd17;
	localparam logic [4:0] S_MWH  = 5'd18;
	localparam logic [4:0] S_SL   = 5'd19;
	localparam logic [4:0] S_DL   = 5'd20;
	localparam logic [4:0] S_FIN  = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.op   = gnll_pkg::OP_NONE;
		cmd.sel  = gnll_pkg::SEL_SQ;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = gnll_pkg::OP_LOAD;
					state_d = S_MSQ;
				end
			end
			S_MSQ: begin
				cmd.op  = gnll_pkg::OP_MUL;
				cmd.sel = gnll_pkg::SEL_SQ;
				state_d = S_SSQ;
			end
			S_SSQ: begin
				cmd.op  = gnll_pkg::OP_DIV_START;
				cmd.sel = gnll_pkg::SEL_SQ;
				state_d = S_DSQ;
			end
			S_DSQ: begin
				cmd.op = gnll_pkg::OP_DIV_STEP;
				if (status.div_last) state_d = S_MMG;
			end
			S_MMG: begin
				cmd.op  = gnll_pkg::OP_MUL;
				cmd.sel = gnll_pkg::SEL_MG;
				state_d = S_SMG;
			end
			S_SMG: begin
				cmd.op  = gnll_pkg::OP_DIV_START;
				cmd.sel = gnll_pkg::SEL_MG;
				state_d = S_DMG;
			end
			S_DMG: begin
				cmd.op = gnll_pkg::OP_DIV_STEP;
				if (status.div_last) state_d = S_LNS;
			end
			S_LNS: begin
				cmd.op  = gnll_pkg::OP_LOG_START;
				state_d = S_LNN;
			end
			S_LNN: begin
				if (status.norm_done) begin
					state_d = S_LNI;
				end else begin
					cmd.op = gnll_pkg::OP_LOG_NORM;
				end
			end
			S_LNI: begin
				cmd.op = gnll_pkg::OP_LOG_ITER;
				if (status.iter_done) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = gnll_pkg::OP_ACC;
				state_d = S_SR;
			end
			S_SR: begin
				cmd.op  = gnll_pkg::OP_DIV_START;
				cmd.sel = gnll_pkg::SEL_R;
				state_d = S_DR;
			end
			S_DR: begin
				cmd.op = gnll_pkg::OP_DIV_STEP;
				if (status.div_last) state_d = S_MR2;
			end
			S_MR2: begin
				cmd.op  = gnll_pkg::OP_MUL;
				cmd.sel = gnll_pkg::SEL_R2;
				state_d = S_SA;
			end
			S_SA: begin
				cmd.op  = gnll_pkg::OP_DIV_START;
				cmd.sel = gnll_pkg::SEL_A;
				state_d = S_DA;
			end
			S_DA: begin
				cmd.op = gnll_pkg::OP_DIV_STEP;
				if (status.div_last) state_d = S_MW;
			end
			S_MW: begin
				cmd.op  = gnll_pkg::OP_CALC_W;
				state_d = S_MWL;
			end
			S_MWL: begin
				cmd.op  = gnll_pkg::OP_MUL;
				cmd.sel = gnll_pkg::SEL_WLO;
				state_d = S_MWH;
			end
			S_MWH: begin
				cmd.op  = gnll_pkg::OP_MUL;
				cmd.sel = gnll_pkg::SEL_WHI;
				state_d = status.last ? S_SL : S_FIN;
			end
			S_SL: begin
				cmd.op  = gnll_pkg::OP_DIV_START;
				cmd.sel = gnll_pkg::SEL_LOSS;
				state_d = S_DL;
			end
			S_DL: begin
				cmd.op = gnll_pkg::OP_DIV_STEP;
				if (status.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.op  = gnll_pkg::OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A result waiting on a blocked output keeps the sequencer parked.
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !status.out_free) |=> (state_q == S_FIN))
		else $error("finish left while output register still occupied");

	// The loss divide only runs for the final element of a set.
	a_loss_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SL) |-> status.last)
		else $error("loss divide started for an element that is not last");

	// A new item is only taken from the idle state.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gnll_pkg::OP_LOAD) |=> (state_q == S_MSQ))
		else $error("load did not start the sequence");

endmodule

FILE: src/gnll_dp.sv
// ----------------------------------------------------------------------------
// Gaussian NLL loss datapath
// Operand registers, shared multiplier, radix-2 divider, log unit, the
// running sum and count, and the output register.
// ----------------------------------------------------------------------------
module gnll_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gnll_pkg::gnll_cmd_t    cmd,
	output gnll_pkg::gnll_status_t status,
	input  gnll_pkg::gnll_cfg_t    cfg,
	input  logic [31:0]            mean,
	input  logic [30:0]            variance,
	input  logic [31:0]            label,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [31:0]            mean_grad,
	output logic [31:0]            var_grad,
	output logic [31:0]            loss,
	output logic                   loss_valid
);

	localparam int CB = gnll_pkg::COUNT_BITS;
	localparam int NW = gnll_pkg::NUM_W;
	localparam int DW = gnll_pkg::DEN_W;

	// Item operands.
	logic        dneg_q;
	logic [32:0] dmag_q;
	logic [31:0] v_q;
	logic        last_q;
	logic        gneg_q;
	logic [31:0] gmag_q;

	// Intermediate results.
	logic [63:0] prod_q;
	logic [62:0] sq_q;
	logic [63:0] mgq_q;
	logic [48:0] r_q;
	logic [32:0] a_q;
	logic [63:0] lq_q;
	logic        wneg_q;
	logic [48:0] wmag_q;
	logic [81:0] wp_q;

	// Divider.
	logic [NW-1:0]             num_q;
	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             den_q;
	logic [gnll_pkg::CNT_W-1:0] cnt_q;
	logic [2:0]                tgt_q;

	// Log unit.
	logic [31:0] m_q;
	logic [4:0]  k_q;
	logic [4:0]  it_q;
	logic [16:0] lacc_q;

	// Running state.
	logic [63:0]   sum_q;
	logic [CB-1:0] count_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] mg_q;
	logic [31:0] vg_q;
	logic [31:0] loss_q;
	logic        lv_q;

	// Combinational helpers.
	logic [32:0]   dd;
	logic [31:0]   vsum;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	logic [NW-1:0] num_init;
	logic [DW-1:0] den_init;
	logic [63:0]   sum_mag;
	logic [DW:0]   div_sh;
	logic          div_ge;
	logic [DW:0]   div_diff;
	logic [NW-1:0] num_n;
	logic [32:0]   log_t;
	logic signed [6:0]  kd;
	logic signed [23:0] ln_v;
	logic signed [63:0] term;
	logic [64:0]   acc_sum;
	logic [48:0]   r2;
	logic [49:0]   w;
	logic signed [65:0] loss_full;
	logic [31:0]   loss_sat;
	logic          finish;

	assign finish = (cmd.op == gnll_pkg::OP_FINISH);

	assign dd   = {mean[31], mean} - {label[31], label};
	assign vsum = {1'b0, variance} + {1'b0, cfg.eps};

	always_comb begin
		case (cmd.sel)
			gnll_pkg::SEL_SQ: begin
				mul_a = dmag_q[31:0];
				mul_b = dmag_q[31:0];
			end
			gnll_pkg::SEL_MG: begin
				mul_a = dmag_q[31:0];
				mul_b = gmag_q;
			end
			gnll_pkg::SEL_R2: begin
				mul_a = r_q[31:0];
				mul_b = r_q[31:0];
			end
			gnll_pkg::SEL_WLO: begin
				mul_a = wmag_q[31:0];
				mul_b = gmag_q;
			end
			gnll_pkg::SEL_WHI: begin
				mul_a = {15'd0, wmag_q[48:32]};
				mul_b = gmag_q;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign sum_mag = sum_q[63] ? (~sum_q + 64'd1) : sum_q;

	// When the difference is exactly 2^32 its low word is zero.
	always_comb begin
		den_init = {1'b0, v_q};
		case (cmd.sel)
			gnll_pkg::SEL_SQ:   num_init = dmag_q[32] ? {1'b1, 64'd0} : {1'b0, prod_q};
			gnll_pkg::SEL_MG:   num_init = dmag_q[32] ? {1'b0, gmag_q, 32'd0}
			                                          : {1'b0, prod_q};
			gnll_pkg::SEL_R:    num_init = {16'd0, dmag_q, 16'd0};
			gnll_pkg::SEL_A:    num_init = {32'd0, 1'b1, 32'd0};
			gnll_pkg::SEL_LOSS: begin
				num_init = {1'b0, sum_mag};
				den_init = DW'({count_q, 1'b0});
			end
			default:            num_init = '0;
		endcase
	end

	assign div_sh   = {rem_q, num_q[NW-1]};
	assign div_ge   = (div_sh >= {1'b0, den_q});
	assign div_diff = div_sh - {1'b0, den_q};
	assign num_n    = {num_q[NW-2:0], div_ge};

	assign log_t = {1'b0, m_q} + ({1'b0, m_q} >> it_q);

	assign kd      = $signed({2'b00, k_q}) - 7'sd15;
	assign ln_v    = 24'(kd * $signed(24'(gnll_pkg::LN2_Q16))) - $signed({7'd0, lacc_q});
	assign term    = $signed({1'b0, sq_q}) + 64'(ln_v);
	assign acc_sum = {sum_q[63], sum_q} + {term[63], term};

	assign r2 = (|r_q[48:32]) ? {1'b1, 48'd0} : {1'b0, prod_q[63:16]};
	assign w  = {17'd0, a_q} - {1'b0, r2};

	assign loss_full = (sum_q[63] ? -$signed({2'b00, lq_q}) : $signed({2'b00, lq_q}))
	                   + 66'(signed'(cfg.loss_offset));
	always_comb begin
		if (loss_full > 66'sd2147483647) begin
			loss_sat = 32'h7fff_ffff;
		end else if (loss_full < -66'sd2147483648) begin
			loss_sat = 32'h8000_0000;
		end else begin
			loss_sat = loss_full[31:0];
		end
	end

	// Payload and work registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			gnll_pkg::OP_LOAD: begin
				dneg_q <= dd[32];
				dmag_q <= dd[32] ? (~dd + 33'd1) : dd;
				v_q    <= (vsum == 32'd0) ? 32'd1 : vsum;
				last_q <= last;
				gneg_q <= cfg.grad_scale[31];
				gmag_q <= cfg.grad_scale[31] ? (~cfg.grad_scale + 32'd1) : cfg.grad_scale;
			end
			gnll_pkg::OP_MUL: begin
				if (cmd.sel == gnll_pkg::SEL_WHI) begin
					wp_q <= {18'd0, prod_q} + {mul_p[49:0], 32'd0};
				end else begin
					prod_q <= mul_p;
				end
			end
			gnll_pkg::OP_DIV_START: begin
				num_q <= num_init;
				den_q <= den_init;
				rem_q <= '0;
				tgt_q <= cmd.sel;
			end
			gnll_pkg::OP_DIV_STEP: begin
				num_q <= num_n;
				rem_q <= div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
				if (status.div_last) begin
					case (tgt_q)
						gnll_pkg::SEL_SQ:   sq_q <= (num_n > {3'd0, 1'b1, 62'd0})
						                            ? {1'b1, 62'd0} : num_n[62:0];
						gnll_pkg::SEL_MG:   mgq_q <= num_n[63:0];
						gnll_pkg::SEL_R:    r_q <= num_n[48:0];
						gnll_pkg::SEL_A:    a_q <= num_n[32:0];
						gnll_pkg::SEL_LOSS: lq_q <= num_n[63:0];
						default:            lq_q <= num_n[63:0];
					endcase
				end
			end
			gnll_pkg::OP_LOG_START: begin
				m_q    <= v_q;
				k_q    <= 5'd31;
				it_q   <= 5'd1;
				lacc_q <= '0;
			end
			gnll_pkg::OP_LOG_NORM: begin
				m_q <= {m_q[30:0], 1'b0};
				k_q <= k_q - 5'd1;
			end
			gnll_pkg::OP_LOG_ITER: begin
				if (!log_t[32]) begin
					m_q    <= log_t[31:0];
					lacc_q <= lacc_q + {1'b0, gnll_pkg::ln_tab(it_q)};
				end
				it_q <= it_q + 5'd1;
			end
			gnll_pkg::OP_CALC_W: begin
				wneg_q <= w[49];
				wmag_q <= w[49] ? 49'(~w + 50'd1) : w[48:0];
			end
			gnll_pkg::OP_FINISH: begin
				mg_q   <= cfg.grad_select[0]
				          ? gnll_pkg::sat_mag({1'b0, mgq_q}, dneg_q ^ gneg_q) : 32'd0;
				vg_q   <= cfg.grad_select[1]
				          ? gnll_pkg::sat_mag(wp_q[81:17], wneg_q ^ gneg_q) : 32'd0;
				loss_q <= last_q ? loss_sat : 32'd0;
				lv_q   <= last_q;
			end
			default: begin
			end
		endcase
	end

	// Control state: divider counter, running sum and count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == gnll_pkg::OP_DIV_START) begin
				cnt_q <= '0;
			end else if (cmd.op == gnll_pkg::OP_DIV_STEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.op == gnll_pkg::OP_ACC) begin
				if (acc_sum[64] != acc_sum[63]) begin
					sum_q <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				end else begin
					sum_q <= acc_sum[63:0];
				end
				if (count_q != {CB{1'b1}}) count_q <= count_q + 1'b1;
			end else if (finish && last_q) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.div_last  = (cnt_q == gnll_pkg::CNT_W'(gnll_pkg::DIV_STEPS - 1));
	assign status.norm_done = m_q[31];
	assign status.iter_done = (it_q == 5'd16);
	assign status.last      = last_q;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign mean_grad  = mg_q;
	assign var_grad   = vg_q;
	assign loss       = loss_q;
	assign loss_valid = lv_q;

	// The loss divide never sees an empty set.
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gnll_pkg::OP_ACC) |=> (count_q != '0))
		else $error("element count zero after accumulation");

	// Every divide runs against a nonzero divisor.
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gnll_pkg::OP_DIV_STEP) |-> (den_q != '0))
		else $error("divide by zero");

	// Normalization only shifts while the top bit is clear.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gnll_pkg::OP_LOG_NORM) |-> (!m_q[31] && k_q != 5'd0))
		else $error("log normalization overran");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Gaussian NLL loss testbench
// Drives elements through the valid/stall input channel and checks every
// result against a bit-accurate predictor of gradients and set loss.
// ----------------------------------------------------------------------------
// The run starts with a short table of hand-picked elements. After that come
// several phases of random sets, each under its own register setting. Both
// channels idle and stall at random, and one phase runs with no idling at all.
// Registers are changed only after every expected result has come back and
// the block has had time to settle.
// ----------------------------------------------------------------------------
module tb_top;

	// One result item as the block reports it.
	typedef struct {
		logic [31:0] mean_grad;
		logic [31:0] var_grad;
		logic [31:0] loss;
		logic        loss_valid;
	} grad_result_t;

	// One row of the directed table. When known is set, the mean gradient and
	// the loss flag are typed in; the other fields come from the predictor.
	typedef struct {
		logic [31:0] mean;
		logic [30:0] variance;
		logic [31:0] label;
		logic        last;
		bit          known;
		logic [31:0] known_mg;
		logic        known_lv;
	} element_row_t;

	localparam int  IDLE_MAX     = 16;
	localparam int  SETTLE_CYC   = 450;
	localparam int  STALL_LIMIT  = 20000;
	localparam int  ITEMS_PER_PH = 160;
	localparam longint SUM_MAX   = 64'sh7fff_ffff_ffff_ffff;
	localparam longint SUM_MIN   = -64'sh7fff_ffff_ffff_ffff - 1;
	localparam longint LN_STEP [17] = '{0, 26573, 14624, 7719, 3973, 2017, 1016, 510,
		256, 128, 64, 32, 16, 8, 4, 2, 1};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] mean;
	logic [30:0] variance;
	logic [31:0] label;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] mean_grad;
	logic [31:0] var_grad;
	logic [31:0] loss;
	logic        loss_valid;

	gaussian_nll_loss_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mean       (mean),
		.variance   (variance),
		.label      (label),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mean_grad  (mean_grad),
		.var_grad   (var_grad),
		.loss       (loss),
		.loss_valid (loss_valid)
	);

	// Predictor copy of the registers and the running set state.
	logic [30:0] eps_q;
	logic [31:0] grad_scale_q;
	logic [31:0] loss_offset_q;
	logic [1:0]  grad_select_q;
	longint      set_sum;
	logic [63:0] set_count;

	grad_result_t pending_results[$];
	int           mismatches;
	bit           quiet_mode;
	int           idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Natural log of a Q16.16 value by normalizing and a shift-add table walk.
	function automatic longint ln_fixed(input logic [63:0] v);
		int          k;
		logic [63:0] m;
		logic [63:0] t;
		longint      acc;
		k = 31;
		acc = 0;
		while (k > 0 && !v[k]) k--;
		m = v << (31 - k);
		for (int i = 1; i <= 16; i++) begin
			t = m + (m >> i);
			if (t < 64'h1_0000_0000) begin
				m = t;
				acc += LN_STEP[i];
			end
		end
		return longint'(k - 15) * gnll_pkg::LN2_Q16 - acc;
	endfunction

	function automatic logic [31:0] clamp_mag(input logic [63:0] mag, input bit neg);
		if (neg)
			return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
		return (mag >= 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
	endfunction

	// Product of a magnitude and the scale magnitude, capped at 2^63.
	function automatic logic [63:0] scaled_mag(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] hi;
		logic [63:0] p;
		hi = (a >> 32) * b;
		if (hi >= 64'h8000_0000) return 64'h8000_0000_0000_0000;
		p = (hi << 32) + (a & 64'hffff_ffff) * b;
		return (p > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : p;
	endfunction

	// Works out the result of one accepted element and updates the set state.
	function automatic grad_result_t predict_element(input logic [31:0] m_in,
			input logic [30:0] v_in, input logic [31:0] l_in, input logic l_last);
		grad_result_t res;
		longint      d;
		logic [63:0] v;
		bit          dneg;
		bit          gneg;
		bit          wneg;
		logic [63:0] dmag;
		logic [63:0] gmag;
		logic [63:0] sq;
		logic [63:0] r;
		logic [63:0] r2;
		logic [63:0] wmag;
		longint      term;
		longint      w;
		longint      lsum;
		d = longint'($signed(m_in)) - longint'($signed(l_in));
		v = 64'(v_in) + 64'(eps_q);
		if (v == 0) v = 1;
		dneg = d < 0;
		dmag = dneg ? 64'(-d) : 64'(d);
		gneg = grad_scale_q[31];
		gmag = gneg ? 64'(-longint'($signed(grad_scale_q))) : 64'(grad_scale_q);

		sq = (dmag * dmag) / v;
		if (sq > 64'h4000_0000_0000_0000) sq = 64'h4000_0000_0000_0000;
		term = longint'(sq) + ln_fixed(v);
		if (term > 0 && set_sum > SUM_MAX - term) set_sum = SUM_MAX;
		else if (term < 0 && set_sum < SUM_MIN - term) set_sum = SUM_MIN;
		else set_sum += term;
		if (set_count < 64'hff_ffff) set_count++;

		res.mean_grad = 32'd0;
		if (grad_select_q[0])
			res.mean_grad = clamp_mag((dmag * gmag) / v, dneg != gneg);

		res.var_grad = 32'd0;
		if (grad_select_q[1]) begin
			r = (dmag << 16) / v;
			r2 = (r >= 64'h1_0000_0000) ? 64'h1_0000_0000_0000 : ((r * r) >> 16);
			w = longint'(64'h1_0000_0000 / v) - longint'(r2);
			wneg = w < 0;
			wmag = wneg ? 64'(-w) : 64'(w);
			res.var_grad = clamp_mag(scaled_mag(wmag, gmag) >> 17, wneg != gneg);
		end

		res.loss = 32'd0;
		res.loss_valid = l_last;
		if (l_last) begin
			lsum = set_sum / longint'(set_count * 2) + longint'($signed(loss_offset_q));
			if (lsum > 64'sd2147483647) lsum = 64'sd2147483647;
			if (lsum < -64'sd2147483648) lsum = -64'sd2147483648;
			res.loss = lsum[31:0];
			set_sum = 0;
			set_count = 0;
		end
		return res;
	endfunction

	// Signed field values biased toward the extremes and small magnitudes.
	function automatic logic [31:0] pick_signed();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_variance();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'h7fff_ffff;
			2: return 31'($urandom_range(0, 1 << 12));
			3: return 31'($urandom_range(0, 1 << 20));
			default: return 31'($urandom);
		endcase
	endfunction

	// Register write: takes effect at the next rising edge.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			gnll_pkg::REG_EPS:         eps_q = value[30:0];
			gnll_pkg::REG_GRAD_SCALE:  grad_scale_q = value;
			gnll_pkg::REG_LOSS_OFFSET: loss_offset_q = value;
			gnll_pkg::REG_GRAD_SELECT: grad_select_q = value[1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] e, input logic [31:0] g,
			input logic [31:0] o, input logic [1:0] s);
		write_reg(gnll_pkg::REG_EPS, e);
		write_reg(gnll_pkg::REG_GRAD_SCALE, g);
		write_reg(gnll_pkg::REG_LOSS_OFFSET, o);
		write_reg(gnll_pkg::REG_GRAD_SELECT, {30'd0, s});
		cfg_wr_en <= 1'b0;
	endtask

	// Holds off the sender until every result is back, then lets the block
	// settle so the next register writes land while it is idle.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Sends one element and records its expected result once accepted. The
	// caller may pass a typed-in mean gradient and loss flag.
	task automatic send_element(input logic [31:0] m_in, input logic [30:0] v_in,
			input logic [31:0] l_in, input logic l_last, input bit known,
			input logic [31:0] known_mg, input logic known_lv);
		int           gap;
		grad_result_t res;
		gap = quiet_mode ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mean     <= m_in;
		variance <= v_in;
		label    <= l_in;
		last     <= l_last;
		do @(posedge clk); while (!(in_valid && !in_stall));
		res = predict_element(m_in, v_in, l_in, l_last);
		if (known) begin
			res.mean_grad = known_mg;
			res.loss_valid = known_lv;
		end
		pending_results.push_back(res);
	endtask

	// Receiver: holds stall for a random count, then takes one result.
	initial begin
		int           wait_n;
		grad_result_t exp_res;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			wait_n = quiet_mode ? 0 : $urandom_range(0, IDLE_MAX);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mg=%h vg=%h loss=%h lv=%b",
						mean_grad, var_grad, loss, loss_valid);
			end else begin
				exp_res = pending_results.pop_front();
				if (mean_grad !== exp_res.mean_grad || var_grad !== exp_res.var_grad ||
						loss !== exp_res.loss || loss_valid !== exp_res.loss_valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: mg %h/%h vg %h/%h loss %h/%h lv %b/%b (exp/act)",
							exp_res.mean_grad, mean_grad, exp_res.var_grad, var_grad,
							exp_res.loss, loss, exp_res.loss_valid, loss_valid);
				end
			end
		end
	end

	// Watchdog: any stretch with no item moving on either side is a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[gaussian_nll_loss_top] ERROR");
			$finish;
		end
	end

	initial begin
		element_row_t dir_rows[$];
		int           set_len;
		int           sent;
		logic [31:0]  rnd_scale;
		mismatches    = 0;
		quiet_mode    = 1'b0;
		eps_q         = 31'd66;
		grad_scale_q  = 32'd65536;
		loss_offset_q = 32'd26155;
		grad_select_q = 2'd3;
		set_sum       = 0;
		set_count     = 0;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = gnll_pkg::REG_EPS;
		cfg_data  = 32'd0;
		in_valid  = 1'b0;
		mean      = 32'd0;
		variance  = 31'd0;
		label     = 32'd0;
		last      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed elements under the reset setting. A mean equal to the
		// label gives a zero mean gradient at once; extremes of the
		// difference saturate the gradients; lone last elements make sets
		// of one.
		dir_rows = '{
			'{32'd0, 31'd0, 32'd0, 1'b0, 1'b1, 32'd0, 1'b0},
			'{32'd0, 31'd0, 32'd0, 1'b1, 1'b1, 32'd0, 1'b1},
			'{32'h0001_0000, 31'h0001_0000, 32'h0001_0000, 1'b1, 1'b1, 32'd0, 1'b1},
			'{32'h7fff_ffff, 31'd0, 32'h8000_0000, 1'b0, 1'b1, 32'h7fff_ffff, 1'b0},
			'{32'h8000_0000, 31'd0, 32'h7fff_ffff, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
			'{32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
			'{32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1, 32'd0, 1'b0},
			'{32'h0002_0000, 31'h0000_4000, 32'hffff_0000, 1'b0, 1'b0, 32'd0, 1'b0},
			'{32'hfff0_0000, 31'h0010_0000, 32'h0000_0001, 1'b0, 1'b0, 32'd0, 1'b0},
			'{32'h0000_0100, 31'h4000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
			'{32'h1234_5678, 31'h0000_0001, 32'hedcb_a988, 1'b1, 1'b0, 32'd0, 1'b0},
			'{32'hffff_ffff, 31'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'd0, 1'b0},
			'{32'haaaa_aaaa, 31'h2aaa_aaaa, 32'h5555_5555, 1'b1, 1'b0, 32'd0, 1'b0}
		};
		foreach (dir_rows[i])
			send_element(dir_rows[i].mean, dir_rows[i].variance, dir_rows[i].label,
				dir_rows[i].last, dir_rows[i].known, dir_rows[i].known_mg,
				dir_rows[i].known_lv);

		// Random phases. Each starts from an idle block with a fresh setting:
		// the defaults, two settings near the register extremes, then partly random ones.
		for (int ph = 0; ph < 6; ph++) begin
			drain_block();
			rnd_scale = pick_signed();
			case (ph)
				0: ;
				1: set_regs(32'd1, 32'h8000_0000, 32'h8000_0000, 2'd0);
				2: set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 2'd1);
				3: set_regs(32'd66, rnd_scale, $urandom, 2'd2);
				4: set_regs(32'($urandom_range(1, 1 << 16)), 32'hffff_0000, 32'd0, 2'd3);
				default: set_regs({1'b1, 31'($urandom_range(1, 32'h7fff_ffff))},
					$urandom, $urandom, 2'd3);
			endcase
			// One phase runs with neither side idling.
			quiet_mode = (ph == 4);
			sent = 0;
			while (sent < ITEMS_PER_PH) begin
				// Mostly proper sets ending in a last element; now and then a
				// long set, and some elements with a random last flag.
				set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 6);
				for (int j = 0; j < set_len; j++) begin
					send_element(pick_signed(), pick_variance(), pick_signed(),
						(j == set_len - 1) ? 1'b1 : 1'($urandom_range(0, 15) == 0),
						1'b0, 32'd0, 1'b0);
					sent++;
				end
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("[gaussian_nll_loss_top] OK");
		else
			$display("[gaussian_nll_loss_top] ERROR");
		$finish;
	end

endmodule

FILE: gaussian_nll_loss_top.f
src/gnll_pkg.sv
src/gnll_ctrl.sv
src/gnll_dp.sv
src/gaussian_nll_loss_top.sv
tb/tb_top.sv
